// ===== rtl/core/char_cell_sprite_blitter_defines.svh =====
// Assertion macros shared by the sprite blitter RTL.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef CHAR_CELL_SPRITE_BLITTER_DEFINES_SVH
`define CHAR_CELL_SPRITE_BLITTER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blitter assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blitter assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ccsb_pkg.sv =====
// Types and fixed constants of the character-cell sprite blitter.
// No dependencies; used by ccsb_addr_gen and the top level.
`default_nettype none

package ccsb_pkg;

  // transaction kinds
  localparam logic KIND_TEXEL = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RENDER_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE_BG  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

  // render modes
  localparam logic [1:0] MODE_OPAQUE     = 2'd0;
  localparam logic [1:0] MODE_SKIP_PCT   = 2'd1;
  localparam logic [1:0] MODE_SKIP_SPACE = 2'd2;

  // color keys
  localparam logic [15:0] KEY_PERCENT = 16'h0025;
  localparam logic [15:0] KEY_SPACE   = 16'h0020;

  // cell word: char [15:0], fg [19:16], bg [23:20]
  localparam int CELL_W = 24;

  // window cell address before the store bound: below 255 * 127
  localparam int TEXEL_ADDR_W = 15;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef struct packed {
    logic signed [15:0] sprite_left;
    logic signed [15:0] sprite_bottom;
    logic [8:0]         sprite_width;
    logic [8:0]         sprite_height;
    logic [1:0]         render_mode;
    logic               overwrite_bg;
    logic [7:0]         screen_width;
    logic [6:0]         screen_height;
  } cfg_t;

  typedef struct packed {
    logic                    hit;
    logic [TEXEL_ADDR_W-1:0] addr;
  } draw_t;

  typedef struct packed {
    logic [15:0] cell_char;
    logic [7:0]  cell_attr;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/ccsb_if.sv =====
// Valid/ready channel interfaces of the sprite blitter: input items and results.
// No dependencies.
`default_nettype none

interface ccsb_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] texel_char;
  logic [3:0]  texel_fore;
  logic [3:0]  texel_back;
  logic        last_texel;
  logic [12:0] cell_index;

  modport source (
    output valid, kind, texel_char, texel_fore, texel_back, last_texel, cell_index,
    input  ready
  );
  modport sink (
    input  valid, kind, texel_char, texel_fore, texel_back, last_texel, cell_index,
    output ready
  );
endinterface

interface ccsb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] cell_char;
  logic [7:0]  cell_attr;

  modport source (
    output valid, cell_char, cell_attr,
    input  ready
  );
  modport sink (
    input  valid, cell_char, cell_attr,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/ccsb_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read returns the old word when it meets a write to the same address.
`default_nettype none

module ccsb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ccsb_addr_gen.sv =====
// Texel placement: window position, clipping, color key and cell address.
// Depends on ccsb_pkg.
`default_nettype none

module ccsb_addr_gen #(
  parameter int MAX_COLS        = 128,
  parameter int MAX_ROWS        = 64,
  parameter int MAX_SPRITE_SIDE = 256,
  localparam int CNT_W  = (MAX_SPRITE_SIDE > 1) ? $clog2(MAX_SPRITE_SIDE) : 1
) (
  input  wire ccsb_pkg::cfg_t   cfg,
  input  wire logic [CNT_W-1:0] col,
  input  wire logic [CNT_W-1:0] row,
  input  wire logic [15:0]      texel_char,
  output ccsb_pkg::draw_t       draw
);

  localparam int SIDE_W = $clog2(MAX_SPRITE_SIDE + 1);
  localparam int PW     = ((SIDE_W > 16) ? SIDE_W : 16) + 3;

  logic [SIDE_W-1:0]     clamp_h;
  logic [7:0]            w_eff;
  logic [6:0]            h_eff;
  logic signed [PW-1:0]  x_pos;
  logic signed [PW-1:0]  y_pos;
  logic signed [PW-1:0]  w_s;
  logic signed [PW-1:0]  h_s;
  logic                  in_x;
  logic                  in_y;
  logic                  key_ok;
  logic [7:0]            dx;
  logic [6:0]            dy;
  logic [ccsb_pkg::TEXEL_ADDR_W-1:0] row_base;

  always_comb begin
    if (cfg.sprite_height == 9'd0) begin
      clamp_h = SIDE_W'(1);
    end else if (32'(cfg.sprite_height) > 32'(MAX_SPRITE_SIDE)) begin
      clamp_h = SIDE_W'(MAX_SPRITE_SIDE);
    end else begin
      clamp_h = SIDE_W'(cfg.sprite_height);
    end

    w_eff = (32'(cfg.screen_width) > 32'(MAX_COLS)) ? 8'(MAX_COLS) : cfg.screen_width;
    h_eff = (32'(cfg.screen_height) > 32'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg.screen_height;
    w_s   = PW'($signed({1'b0, w_eff}));
    h_s   = PW'($signed({1'b0, h_eff}));

    x_pos = PW'(cfg.sprite_left) + PW'($signed({1'b0, col}));
    // top texture row lands on the highest window row of the sprite
    y_pos = PW'(cfg.sprite_bottom) + PW'($signed({1'b0, clamp_h})) - PW'(1)
            - PW'($signed({1'b0, row}));

    in_x = (x_pos >= PW'(1)) && (x_pos <= w_s);
    in_y = (y_pos >= PW'(1)) && (y_pos <= h_s);

    case (cfg.render_mode)
      ccsb_pkg::MODE_OPAQUE:     key_ok = 1'b1;
      ccsb_pkg::MODE_SKIP_PCT:   key_ok = (texel_char != ccsb_pkg::KEY_PERCENT);
      ccsb_pkg::MODE_SKIP_SPACE: key_ok = (texel_char != ccsb_pkg::KEY_SPACE);
      default:                   key_ok = 1'b0;
    endcase

    // row 0 of the store is the top window row
    dx       = 8'(x_pos - PW'(1));
    dy       = 7'(h_s - y_pos);
    row_base = ccsb_pkg::TEXEL_ADDR_W'(dy) * ccsb_pkg::TEXEL_ADDR_W'(w_eff);

    draw.hit  = key_ok && in_x && in_y;
    draw.addr = ccsb_pkg::TEXEL_ADDR_W'(dx) + row_base;
  end

endmodule

`default_nettype wire

// ===== rtl/core/char_cell_sprite_blitter.sv =====
// Top level of the character-cell sprite blitter: config registers, texel
// counters, frame store pipeline and result queue.
// Depends on ccsb_pkg, ccsb_if, ccsb_ram, ccsb_addr_gen and the defines header.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-----------------------------------------
//  in_ch    | in  | valid/ready         | kind, texel_char/fore/back, last_texel,
//           |     |                     | cell_index
//  out_ch   | out | valid/ready         | cell_char, cell_attr (read transactions)
//  cfg_*    | in  | cfg_we, no wait     | cfg_index, cfg_wdata
//
// One transaction per cycle while in_ch.ready is high: register, place and read
// the store, then merge and write back in the next cycle. A read result is
// pushed into the result queue from stage 2, after the registered store read.
// After reset a clearing pass writes zero to all MAX_COLS*MAX_ROWS cells, one
// per cycle; in_ch.ready stays low for those cycles. Ready also drops while
// queued plus in-flight read results fill the four-entry result queue.
`default_nettype none
`include "char_cell_sprite_blitter_defines.svh"

module char_cell_sprite_blitter #(
  parameter int MAX_COLS        = 128,
  parameter int MAX_ROWS        = 64,
  parameter int MAX_SPRITE_SIDE = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ccsb_in_if.sink                                in_ch,
  ccsb_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [ccsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ccsb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW          = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
  localparam int CNT_W       = (MAX_SPRITE_SIDE > 1) ? $clog2(MAX_SPRITE_SIDE) : 1;
  localparam int SIDE_W      = $clog2(MAX_SPRITE_SIDE + 1);

  // ---------------- configuration ----------------
  ccsb_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sprite_left   <= '0;
      cfg_r.sprite_bottom <= '0;
      cfg_r.sprite_width  <= 9'd1;
      cfg_r.sprite_height <= 9'd1;
      cfg_r.render_mode   <= ccsb_pkg::MODE_OPAQUE;
      cfg_r.overwrite_bg  <= 1'b1;
      cfg_r.screen_width  <= 8'd128;
      cfg_r.screen_height <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        ccsb_pkg::REG_SPRITE_LEFT:   cfg_r.sprite_left   <= $signed(cfg_wdata);
        ccsb_pkg::REG_SPRITE_BOTTOM: cfg_r.sprite_bottom <= $signed(cfg_wdata);
        ccsb_pkg::REG_SPRITE_WIDTH:  cfg_r.sprite_width  <= cfg_wdata[8:0];
        ccsb_pkg::REG_SPRITE_HEIGHT: cfg_r.sprite_height <= cfg_wdata[8:0];
        ccsb_pkg::REG_RENDER_MODE:   cfg_r.render_mode   <= cfg_wdata[1:0];
        ccsb_pkg::REG_OVERWRITE_BG:  cfg_r.overwrite_bg  <= cfg_wdata[0];
        ccsb_pkg::REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_wdata[7:0];
        ccsb_pkg::REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // ---------------- clearing pass ----------------
  logic          clear_done_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_done_r <= 1'b0;
      clr_addr_r   <= '0;
    end else if (!clear_done_r) begin
      if (clr_addr_r == AW'(STORE_CELLS - 1)) begin
        clear_done_r <= 1'b1;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  // ---------------- input side ----------------
  logic                          in_ready;
  logic                          in_acc;
  logic [1:0]                    inflight;
  logic [ccsb_pkg::OUT_CNT_W-1:0] credit_used;
  logic [ccsb_pkg::OUT_CNT_W-1:0] ff_cnt_r;

  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [15:0] s1_char_r;
  logic [3:0]  s1_fore_r;
  logic [3:0]  s1_back_r;
  logic [12:0] s1_idx_r;
  logic [CNT_W-1:0] s1_col_r;
  logic [CNT_W-1:0] s1_row_r;

  logic        s2_valid_r;
  logic        s2_kind_r;
  logic        s2_write_r;
  logic        s2_in_range_r;
  logic [AW-1:0] s2_addr_r;
  logic [15:0] s2_char_r;
  logic [3:0]  s2_fore_r;
  logic [3:0]  s2_back_r;

  always_comb begin
    inflight    = 2'(s1_valid_r && (s1_kind_r == ccsb_pkg::KIND_READ))
                + 2'(s2_valid_r && (s2_kind_r == ccsb_pkg::KIND_READ));
    credit_used = ff_cnt_r + ccsb_pkg::OUT_CNT_W'(inflight);
    in_ready    = clear_done_r && (credit_used < ccsb_pkg::OUT_CNT_W'(ccsb_pkg::OUT_DEPTH));
  end

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  // ---------------- texel counters ----------------
  logic [CNT_W-1:0]  col_r;
  logic [CNT_W-1:0]  row_r;
  logic [CNT_W-1:0]  col_nxt;
  logic [CNT_W-1:0]  row_nxt;
  logic [SIDE_W-1:0] clamp_w;
  logic [CNT_W:0]    col_inc;

  always_comb begin
    if (cfg_r.sprite_width == 9'd0) begin
      clamp_w = SIDE_W'(1);
    end else if (32'(cfg_r.sprite_width) > 32'(MAX_SPRITE_SIDE)) begin
      clamp_w = SIDE_W'(MAX_SPRITE_SIDE);
    end else begin
      clamp_w = SIDE_W'(cfg_r.sprite_width);
    end

    col_inc = {1'b0, col_r} + (CNT_W + 1)'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_ch.last_texel) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (32'(col_inc) >= 32'(clamp_w)) begin
      col_nxt = '0;
      row_nxt = (row_r == CNT_W'(MAX_SPRITE_SIDE - 1)) ? '0 : row_r + CNT_W'(1);
    end else begin
      col_nxt = col_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc && (in_ch.kind == ccsb_pkg::KIND_TEXEL)) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: place texel, issue store read ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_ch.kind;
      s1_char_r <= in_ch.texel_char;
      s1_fore_r <= in_ch.texel_fore;
      s1_back_r <= in_ch.texel_back;
      s1_idx_r  <= in_ch.cell_index;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
    end
  end

  ccsb_pkg::draw_t draw;

  ccsb_addr_gen #(
    .MAX_COLS        (MAX_COLS),
    .MAX_ROWS        (MAX_ROWS),
    .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE)
  ) u_addr_gen (
    .cfg        (cfg_r),
    .col        (s1_col_r),
    .row        (s1_row_r),
    .texel_char (s1_char_r),
    .draw       (draw)
  );

  logic          s1_write;
  logic          s1_in_range;
  logic [AW-1:0] ram_raddr;

  always_comb begin
    s1_write    = (s1_kind_r == ccsb_pkg::KIND_TEXEL) && draw.hit
               && (32'(draw.addr) < 32'(STORE_CELLS));
    s1_in_range = 32'(s1_idx_r) < 32'(STORE_CELLS);
    ram_raddr   = (s1_kind_r == ccsb_pkg::KIND_READ) ? AW'(s1_idx_r) : AW'(draw.addr);
  end

  // ---------------- stage 2: merge and write back ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_kind_r     <= s1_kind_r;
    s2_write_r    <= s1_write;
    s2_in_range_r <= s1_in_range;
    s2_addr_r     <= ram_raddr;
    s2_char_r     <= s1_char_r;
    s2_fore_r     <= s1_fore_r;
    s2_back_r     <= s1_back_r;
  end

  logic [ccsb_pkg::CELL_W-1:0] ram_rdata;
  logic [ccsb_pkg::CELL_W-1:0] old_cell;
  logic [ccsb_pkg::CELL_W-1:0] new_cell;
  logic [3:0]                  new_back;
  logic                        s2_do_write;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ccsb_pkg::CELL_W-1:0] ram_wdata;

  // last write, for the read that was issued in the same cycle
  logic                        wl_valid_r;
  logic [AW-1:0]               wl_addr_r;
  logic [ccsb_pkg::CELL_W-1:0] wl_data_r;

  always_comb begin
    old_cell    = (wl_valid_r && (wl_addr_r == s2_addr_r)) ? wl_data_r : ram_rdata;
    new_back    = cfg_r.overwrite_bg ? s2_back_r : old_cell[23:20];
    new_cell    = {new_back, s2_fore_r, s2_char_r};
    s2_do_write = s2_valid_r && s2_write_r;
    ram_we      = !clear_done_r || s2_do_write;
    ram_waddr   = clear_done_r ? s2_addr_r : clr_addr_r;
    ram_wdata   = clear_done_r ? new_cell : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_valid_r <= 1'b0;
    end else begin
      wl_valid_r <= s2_do_write;
    end
  end

  always_ff @(posedge clk) begin
    wl_addr_r <= s2_addr_r;
    wl_data_r <= new_cell;
  end

  ccsb_ram #(
    .WIDTH (ccsb_pkg::CELL_W),
    .DEPTH (STORE_CELLS)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- result queue ----------------
  ccsb_pkg::out_item_t            ff_mem_r [ccsb_pkg::OUT_DEPTH];
  ccsb_pkg::out_item_t            push_item;
  logic [ccsb_pkg::OUT_PTR_W-1:0] ff_wr_ptr_r;
  logic [ccsb_pkg::OUT_PTR_W-1:0] ff_rd_ptr_r;
  logic                           ff_push;
  logic                           ff_pop;

  always_comb begin
    ff_push             = s2_valid_r && (s2_kind_r == ccsb_pkg::KIND_READ);
    ff_pop              = out_ch.valid && out_ch.ready;
    push_item.cell_char = s2_in_range_r ? old_cell[15:0] : 16'd0;
    push_item.cell_attr = s2_in_range_r ? old_cell[23:16] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_wr_ptr_r <= '0;
      ff_rd_ptr_r <= '0;
      ff_cnt_r    <= '0;
    end else begin
      if (ff_push) begin
        ff_wr_ptr_r <= ff_wr_ptr_r + ccsb_pkg::OUT_PTR_W'(1);
      end
      if (ff_pop) begin
        ff_rd_ptr_r <= ff_rd_ptr_r + ccsb_pkg::OUT_PTR_W'(1);
      end
      if (ff_push && !ff_pop) begin
        ff_cnt_r <= ff_cnt_r + ccsb_pkg::OUT_CNT_W'(1);
      end else if (!ff_push && ff_pop) begin
        ff_cnt_r <= ff_cnt_r - ccsb_pkg::OUT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ff_push) begin
      ff_mem_r[ff_wr_ptr_r] <= push_item;
    end
  end

  assign out_ch.valid     = (ff_cnt_r != '0);
  assign out_ch.cell_char = ff_mem_r[ff_rd_ptr_r].cell_char;
  assign out_ch.cell_attr = ff_mem_r[ff_rd_ptr_r].cell_attr;

  // ---------------- assertions ----------------
  `ASSERT_IMPLIES(a_queue_no_overflow, clk, rst_n, ff_push && !ff_pop,
    ff_cnt_r < ccsb_pkg::OUT_CNT_W'(ccsb_pkg::OUT_DEPTH))
  `ASSERT_IMPLIES(a_credit_bound, clk, rst_n, 1'b1,
    credit_used <= ccsb_pkg::OUT_CNT_W'(ccsb_pkg::OUT_DEPTH))
  `ASSERT_IMPLIES(a_no_work_in_clear, clk, rst_n, !clear_done_r,
    !s1_valid_r && !s2_valid_r)
  `ASSERT_NEXT(a_read_reaches_queue, clk, rst_n,
    s1_valid_r && (s1_kind_r == ccsb_pkg::KIND_READ), ff_push)

endmodule

`default_nettype wire
